// ===== hw/rtl/sstf_pkg.sv =====
// Shared types and constants for the SSTF disk scheduler.
package sstf_pkg;

  localparam int STATUS_W = 2;
  localparam int POS_W    = 16;
  localparam int TOTAL_W  = 22;
  localparam int SUM_W    = 23;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_START  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_SERVED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sstf_cell.sv =====
// One queue cell: holds a request track and its pending flag, shifts toward the head.
module sstf_cell #(
  parameter int TRACK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sstf_pkg::cell_ctl_t   ctl,
  input  logic [TRACK_BITS-1:0] d_track,
  input  logic                  d_pend,
  output logic [TRACK_BITS-1:0] q_track,
  output logic                  q_pend
);
  import sstf_pkg::*;

  logic [TRACK_BITS-1:0] track_r;
  logic                  pend_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      track_r <= d_track;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      pend_r <= 1'b0;
    end else if (ctl.shift) begin
      pend_r <= d_pend;
    end
  end

  assign q_track = track_r;
  assign q_pend  = pend_r;

endmodule

// ===== hw/rtl/sstf_disk_scheduler.sv =====
// Top level: SSTF scheduler built as a rotating ring of request cells.
//
//  channel  direction  ports
//  in       sink       in_valid, in_ready, in_opcode, in_position
//  out      source     out_valid, out_ready, out_status, out_served_track,
//                      out_seek_distance, out_total_movement, out_is_last
//
// An append gives no word unless the queue is full.
// Each served request costs one full rotation of the ring (cell 0 is
// compared against the best so far at each step), then an emit.
// Reset clears all pending flags and control state.
// A stalled output word holds the ring; new items wait until the run ends.
module sstf_disk_scheduler #(
  parameter int MAX_REQUESTS = 64,
  parameter int TRACK_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [sstf_pkg::POS_W-1:0]      in_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sstf_pkg::STATUS_W-1:0]   out_status,
  output logic [sstf_pkg::POS_W-1:0]      out_served_track,
  output logic [sstf_pkg::POS_W-1:0]      out_seek_distance,
  output logic [sstf_pkg::TOTAL_W-1:0]    out_total_movement,
  output logic                            out_is_last
);
  import sstf_pkg::*;

  localparam int N  = MAX_REQUESTS;
  localparam int KW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int AW = ((TRACK_BITS > SUM_W) ? TRACK_BITS : SUM_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t                state_r;
  logic [KW-1:0]         k_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         steps_r;
  logic [TRACK_BITS-1:0] head_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  found_r;
  logic [TRACK_BITS-1:0] bt_r;
  logic [TRACK_BITS-1:0] bd_r;
  logic [KW-1:0]         bk_r;
  logic                  clr_v_r;
  logic [KW-1:0]         clr_k_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [POS_W-1:0]      out_track_r;
  logic [POS_W-1:0]      out_dist_r;
  logic [TOTAL_W-1:0]    out_total_r;
  logic                  out_last_r;

  logic [TRACK_BITS-1:0] trk [N];
  logic                  pnd [N];
  cell_ctl_t             ctl;

  logic                  slot_free;
  logic                  acc;
  logic                  app;
  logic [TRACK_BITS-1:0] pos_m;
  logic [TRACK_BITS-1:0] c0_t;
  logic [TRACK_BITS-1:0] c0_dist;
  logic                  drop;
  logic                  better;
  logic [TRACK_BITS-1:0] tail_t;
  logic                  tail_p;
  logic [AW-1:0]         sum_wide;
  logic [SUM_W-1:0]      sum_nxt;
  logic [TOTAL_W-1:0]    total_nxt;
  logic                  run_last;
  logic                  emit_go;
  logic                  out_load;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign app       = acc && (in_opcode == OP_APPEND) && (cnt_r != CW'(N));
  assign pos_m     = TRACK_BITS'(in_position);

  assign c0_t    = trk[0];
  assign c0_dist = (c0_t >= head_r) ? (c0_t - head_r) : (head_r - c0_t);
  assign drop    = (state_r == S_SCAN) && clr_v_r && (k_r == clr_k_r);
  assign better  = pnd[0] && !drop &&
                   (!found_r || (c0_dist < bd_r) || ((c0_dist == bd_r) && (c0_t < bt_r)));

  assign tail_t = app ? pos_m : trk[0];
  assign tail_p = app ? 1'b1 : (pnd[0] && !drop);

  assign sum_wide  = AW'(sum_r) + AW'(bd_r);
  assign sum_nxt   = (sum_wide > AW'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_wide);
  assign total_nxt = (sum_nxt > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_nxt);
  assign run_last  = ((steps_r + CW'(1)) == cnt_r);
  assign emit_go   = (state_r == S_EMIT) && slot_free;
  assign out_load  = emit_go ||
                     (acc && ((in_opcode == OP_APPEND) ? (cnt_r == CW'(N)) : (cnt_r == '0)));

  assign ctl.shift = app || (state_r == S_SCAN);
  assign ctl.clear = emit_go && run_last;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [TRACK_BITS-1:0] d_t;
    logic                  d_p;
    if (i == N - 1) begin : g_tail
      assign d_t = tail_t;
      assign d_p = tail_p;
    end else begin : g_mid
      assign d_t = trk[i+1];
      assign d_p = pnd[i+1];
    end
    sstf_cell #(
      .TRACK_BITS(TRACK_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .d_track (d_t),
      .d_pend  (d_p),
      .q_track (trk[i]),
      .q_pend  (pnd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cnt_r       <= '0;
      steps_r     <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      found_r     <= 1'b0;
      clr_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (in_opcode == OP_APPEND) begin
              if (cnt_r == CW'(N)) begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_FULL;
                out_track_r  <= '0;
                out_dist_r   <= '0;
                out_total_r  <= '0;
                out_last_r   <= 1'b1;
              end else begin
                cnt_r <= cnt_r + CW'(1);
              end
            end else begin
              head_r <= pos_m;
              sum_r  <= '0;
              if (cnt_r == '0) begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_EMPTY;
                out_track_r  <= '0;
                out_dist_r   <= '0;
                out_total_r  <= '0;
                out_last_r   <= 1'b1;
              end else begin
                state_r <= S_SCAN;
                k_r     <= '0;
                steps_r <= '0;
                found_r <= 1'b0;
                clr_v_r <= 1'b0;
              end
            end
          end
        end
        S_SCAN: begin
          if (better) begin
            found_r <= 1'b1;
            bt_r    <= c0_t;
            bd_r    <= c0_dist;
            bk_r    <= k_r;
          end
          if (k_r == KW'(N - 1)) begin
            k_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_SERVED;
            out_track_r  <= POS_W'(bt_r);
            out_dist_r   <= POS_W'(bd_r);
            out_total_r  <= total_nxt;
            out_last_r   <= run_last;
            head_r       <= bt_r;
            sum_r        <= sum_nxt;
            clr_v_r      <= 1'b1;
            clr_k_r      <= bk_r;
            found_r      <= 1'b0;
            steps_r      <= steps_r + CW'(1);
            if (run_last) begin
              cnt_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_served_track   = out_track_r;
  assign out_seek_distance  = out_dist_r;
  assign out_total_movement = out_total_r;
  assign out_is_last        = out_last_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input ready outside idle");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && run_last) |=> ((state_r == S_IDLE) && (cnt_r == '0) && !pnd[0]))
    else $error("queue not cleared after last served word");

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != '0) |-> (state_r == S_SCAN))
    else $error("rotation counter moving outside scan");

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> found_r)
    else $error("emit without a selected request");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for sstf_disk_scheduler: predicts the service order and checks each result word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sstf_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    track;
    logic [POS_W-1:0]    seek;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } svc_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_APPEND;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0] out_served_track;
  logic [POS_W-1:0] out_seek_distance;
  logic [TOTAL_W-1:0] out_total_movement;
  logic out_is_last;

  sstf_disk_scheduler #(
    .MAX_REQUESTS(QUEUE_DEPTH),
    .TRACK_BITS(POS_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_served_track(out_served_track),
    .out_seek_distance(out_seek_distance),
    .out_total_movement(out_total_movement),
    .out_is_last(out_is_last)
  );

  // shadow of the scheduler state
  logic [POS_W-1:0] req_track [QUEUE_DEPTH];
  bit               req_pending [QUEUE_DEPTH];
  int               req_count = 0;
  logic [POS_W-1:0] head_pos = '0;
  logic [SUM_W-1:0] move_sum = '0;

  svc_word_t service_order_q[$];
  int errors = 0;
  int words_sent = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold = 0;
  int rx_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void schedule_step(logic op, logic [POS_W-1:0] pos);
    svc_word_t w;
    int n, step, j, best;
    bit found;
    logic [POS_W-1:0] t, d, best_d, best_t;
    logic [SUM_W:0] acc;
    if (op == OP_APPEND) begin
      if (req_count >= QUEUE_DEPTH) begin
        w = '{ST_FULL, '0, '0, '0, 1'b1};
        service_order_q.push_back(w);
      end else begin
        req_track[req_count] = pos;
        req_pending[req_count] = 1'b1;
        req_count++;
      end
      return;
    end
    head_pos = pos;
    move_sum = '0;
    n = req_count;
    if (n == 0) begin
      w = '{ST_EMPTY, '0, '0, '0, 1'b1};
      service_order_q.push_back(w);
      return;
    end
    for (step = 0; step < n; step++) begin
      found = 1'b0;
      best = 0;
      best_d = '0;
      best_t = '0;
      for (j = 0; j < n; j++) begin
        if (req_pending[j]) begin
          t = req_track[j];
          d = (t >= head_pos) ? t - head_pos : head_pos - t;
          if (!found || d < best_d || (d == best_d && t < best_t)) begin
            found = 1'b1;
            best = j;
            best_d = d;
            best_t = t;
          end
        end
      end
      req_pending[best] = 1'b0;
      head_pos = best_t;
      acc = move_sum + best_d;
      move_sum = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
      w.status = ST_SERVED;
      w.track = best_t;
      w.seek = best_d;
      w.total = (move_sum > TOTAL_MAX) ? TOTAL_MAX : move_sum[TOTAL_W-1:0];
      w.last = (step + 1 == n);
      service_order_q.push_back(w);
    end
    for (j = 0; j < QUEUE_DEPTH; j++) req_pending[j] = 1'b0;
    req_count = 0;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_word();
    svc_word_t w;
    if (service_order_q.size() == 0) begin
      flag_mismatch("unexpected word, track", 32'(out_served_track), 32'd0);
      return;
    end
    w = service_order_q.pop_front();
    if (out_status !== w.status)
      flag_mismatch("status", 32'(out_status), 32'(w.status));
    if (out_served_track !== w.track)
      flag_mismatch("served_track", 32'(out_served_track), 32'(w.track));
    if (out_seek_distance !== w.seek)
      flag_mismatch("seek_distance", 32'(out_seek_distance), 32'(w.seek));
    if (out_total_movement !== w.total)
      flag_mismatch("total_movement", 32'(out_total_movement), 32'(w.total));
    if (out_is_last !== w.last)
      flag_mismatch("is_last", 32'(out_is_last), 32'(w.last));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) schedule_step(in_opcode, in_position);
      if (out_valid && out_ready) check_word();
    end
  end

  // receiver: long hold-offs on request, random short stalls otherwise
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      rx_gap = $urandom_range(1, 16) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_request(logic op, logic [POS_W-1:0] pos);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (service_order_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_batch(int n, bit clustered);
    int k;
    logic [POS_W-1:0] base;
    base = POS_W'($urandom);
    for (k = 0; k < n; k++)
      push_request(OP_APPEND,
                   clustered ? POS_W'(base + $urandom_range(0, 8)) : POS_W'($urandom));
    push_request(OP_START,
                 clustered ? POS_W'(base + $urandom_range(0, 8)) : POS_W'($urandom));
  endtask

  task automatic test_empty_start();
    push_request(OP_START, 16'h0000);
    push_request(OP_START, 16'hFFFF);
  endtask

  task automatic test_extremes();
    push_request(OP_APPEND, 16'hFFFF);
    push_request(OP_APPEND, 16'h0000);
    push_request(OP_START, 16'h0000);
    push_request(OP_APPEND, 16'h0000);
    push_request(OP_START, 16'hFFFF);
  endtask

  task automatic test_ties();
    push_request(OP_APPEND, 16'd110);
    push_request(OP_APPEND, 16'd90);
    push_request(OP_APPEND, 16'd110);
    push_request(OP_APPEND, 16'd90);
    push_request(OP_APPEND, 16'd100);
    push_request(OP_START, 16'd100);
  endtask

  task automatic test_full_queue();
    int k;
    wait_drained();
    for (k = 0; k < QUEUE_DEPTH; k++) push_request(OP_APPEND, POS_W'($urandom));
    push_request(OP_APPEND, 16'h0000);
    push_request(OP_APPEND, 16'hFFFF);
    push_request(OP_START, POS_W'($urandom));
    for (k = 0; k < QUEUE_DEPTH; k++) push_request(OP_APPEND, k[0] ? 16'hFFFF : 16'h0000);
    push_request(OP_APPEND, POS_W'($urandom));
    push_request(OP_START, 16'h7FFF);
  endtask

  task automatic test_backpressure();
    wait_drained();
    rx_hold = 600;
    run_batch(10, 1'b0);
    run_batch(6, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int r;
    while (words_sent < 260) begin
      r = $urandom_range(0, 9);
      if (r == 0) push_request(OP_START, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      else if (r == 1) wait_drained();
      else if (r == 2) run_batch($urandom_range(9, 24), 1'b0);
      else run_batch($urandom_range(1, 8), r < 6);
    end
  endtask

  task automatic test_no_idle_tail();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (words_sent < 300) run_batch($urandom_range(1, 8), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_start();
    test_extremes();
    test_ties();
    test_full_queue();
    test_backpressure();
    test_random_mix();
    test_no_idle_tail();
    wait_drained();
    repeat (150) @(posedge clk);
    if (errors == 0 && service_order_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
